// ===== rtl/core/spmq_pkg.sv =====
`default_nettype none

package spmq_pkg;

    localparam int NUM_TASKS_DEF  = 8;
    localparam int POOL_SLOTS_DEF = 64;

    localparam logic FUNC_SEND = 1'b0;
    localparam logic FUNC_RECV = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int        GROUP_BITS  = 4;
    localparam logic [7:0] LOW_NONE   = 8'hFF;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // lowest set bit of a nibble, LOW_NONE when the nibble is zero
    localparam logic [7:0] LOWEST_SET [16] = '{
        8'd255, 8'd0, 8'd1, 8'd0, 8'd2, 8'd0, 8'd1, 8'd0,
        8'd3,   8'd0, 8'd1, 8'd0, 8'd2, 8'd0, 8'd1, 8'd0
    };

    typedef struct packed {
        logic       func;
        logic [2:0] task_id;
        logic [7:0] message;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] message_out;
        logic       pending;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/spmq_ram.sv =====
`default_nettype none

module spmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/spmq_alloc.sv =====
`default_nettype none

module spmq_alloc import spmq_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          alloc_en,
    input  wire logic [$clog2(POOL_SLOTS)-1:0] alloc_slot,
    input  wire logic                          release_en,
    input  wire logic [$clog2(POOL_SLOTS)-1:0] release_slot,
    output logic                               free_any,
    output logic      [$clog2(POOL_SLOTS)-1:0] free_slot
);

    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int NUM_GROUPS = (POOL_SLOTS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int PAD_W      = NUM_GROUPS * GROUP_BITS;

    logic [POOL_SLOTS-1:0] free_reg;
    logic [PAD_W-1:0]      free_padded;
    logic                  grp_any_reg  [NUM_GROUPS];
    logic [1:0]            grp_low_reg  [NUM_GROUPS];
    logic                  grp_any_next [NUM_GROUPS];
    logic [1:0]            grp_low_next [NUM_GROUPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            if (alloc_en)
            begin
                free_reg[alloc_slot] <= 1'b0;
            end
            else if (release_en)
            begin
                free_reg[release_slot] <= 1'b1;
            end
        end
    end

    // first level: lowest free bit inside each nibble
    always_comb
    begin
        logic [3:0] nib;
        nib = '0;
        free_padded = PAD_W'(free_reg);
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            nib = free_padded[g*GROUP_BITS +: GROUP_BITS] & NIBBLE_MASK;
            grp_any_next[g] = (LOWEST_SET[nib] != LOW_NONE);
            grp_low_next[g] = LOWEST_SET[nib][1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        grp_low_reg <= grp_low_next;
    end

    // second level: lowest nibble that has a free slot
    always_comb
    begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(g * GROUP_BITS + int'(grp_low_reg[g]));
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/spmq_dp.sv =====
`default_nettype none

module spmq_dp import spmq_pkg::*; #(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire dp_cmd_t cmd,
    input  wire req_t    request,
    output logic         done,
    output rsp_t         result
);

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int TASK_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    req_t                 req_reg;
    rsp_t                 result_reg;
    rsp_t                 result_next;
    logic                 done_reg;
    logic [SLOT_W-1:0]    head_reg [NUM_TASKS];
    logic [SLOT_W-1:0]    tail_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] nonempty_reg;
    logic [NUM_TASKS-1:0] nonempty_next;
    logic [SLOT_W-1:0]    head_next;
    logic                 head_wr;
    logic                 tail_wr;

    logic [TASK_W-1:0]    idx;
    logic                 in_range;
    logic [SLOT_W-1:0]    cur_head;
    logic [SLOT_W-1:0]    cur_tail;
    logic                 cur_ne;

    logic                 free_any;
    logic [SLOT_W-1:0]    free_slot;
    logic                 alloc_en;
    logic                 release_en;
    logic                 msg_wr_en;
    logic                 link_wr_en;
    logic [7:0]           rd_msg;
    logic [SLOT_W-1:0]    rd_link;

    assign idx      = TASK_W'(req_reg.task_id);
    assign in_range = (int'(req_reg.task_id) < NUM_TASKS);
    assign cur_head = head_reg[idx];
    assign cur_tail = tail_reg[idx];
    assign cur_ne   = in_range && nonempty_reg[idx];

    spmq_alloc #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_alloc (
        .clk          (clk),
        .rst_n        (rst_n),
        .alloc_en     (alloc_en),
        .alloc_slot   (free_slot),
        .release_en   (release_en),
        .release_slot (cur_head),
        .free_any     (free_any),
        .free_slot    (free_slot)
    );

    spmq_ram #(
        .WIDTH (8),
        .DEPTH (POOL_SLOTS)
    ) u_msg_ram (
        .clk     (clk),
        .wr_en   (msg_wr_en),
        .wr_addr (free_slot),
        .wr_data (req_reg.message),
        .rd_addr (cur_head),
        .rd_data (rd_msg)
    );

    spmq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (cur_tail),
        .wr_data (free_slot),
        .rd_addr (cur_head),
        .rd_data (rd_link)
    );

    always_comb
    begin
        result_next   = '{status: ST_OK, message_out: 8'd0, pending: 1'b0};
        nonempty_next = nonempty_reg;
        head_next     = free_slot;
        head_wr       = 1'b0;
        tail_wr       = 1'b0;
        alloc_en      = 1'b0;
        release_en    = 1'b0;
        msg_wr_en     = 1'b0;
        link_wr_en    = 1'b0;
        if (!in_range)
        begin
            result_next.status = (req_reg.func == FUNC_SEND) ? ST_FULL : ST_EMPTY;
        end
        else if (req_reg.func == FUNC_SEND)
        begin
            if (!free_any)
            begin
                result_next.status  = ST_FULL;
                result_next.pending = cur_ne;
            end
            else
            begin
                result_next.pending = 1'b1;
                alloc_en            = cmd.commit;
                msg_wr_en           = cmd.commit;
                tail_wr             = cmd.commit;
                if (cur_ne)
                begin
                    link_wr_en = cmd.commit;
                end
                else
                begin
                    head_wr = cmd.commit;
                    if (cmd.commit)
                    begin
                        nonempty_next[idx] = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (!cur_ne)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.message_out = rd_msg;
                release_en              = cmd.commit;
                if (cur_head == cur_tail)
                begin
                    result_next.pending = 1'b0;
                    if (cmd.commit)
                    begin
                        nonempty_next[idx] = 1'b0;
                    end
                end
                else
                begin
                    result_next.pending = 1'b1;
                    head_next           = rd_link;
                    head_wr             = cmd.commit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            nonempty_reg <= nonempty_next;
            done_reg     <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
        if (head_wr)
        begin
            head_reg[idx] <= head_next;
        end
        if (tail_wr)
        begin
            tail_reg[idx] <= free_slot;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spmq_ctrl.sv =====
`default_nettype none

module spmq_ctrl import spmq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ACCESS = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg == S_ACCESS);
    assign accept = start && !busy;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = accept ? S_ACCESS : S_IDLE;
            end
            S_ACCESS:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = accept ? S_ACCESS : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load   = accept;
    assign cmd.commit = (state_reg == S_COMMIT);

endmodule

`default_nettype wire

// ===== rtl/core/shared_pool_multi_queue_core.sv =====
// shared pool multi queue core
// per-task fifo message queues kept as linked lists in one shared slot pool
// request channel: a send or receive transaction is taken at a rising edge
//   with start high and busy low; request carries func, task_id and message
// result channel: done is high for exactly one cycle with result holding
//   status, message_out and pending; the receiver cannot stall it
// overlap: busy is high for the one
//   cycle in which head and slot memories are read, a new request is taken
//   in the same cycle the previous one writes back
// free slot search is a two level nibble tree whose first level is
//   registered from the free bitmap
// reset: all slots free, all queues empty, no result pending; head, tail,
//   slot message and slot link storage hold no defined value until written
`default_nettype none

module shared_pool_multi_queue_core import spmq_pkg::*; #(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      done,
    output rsp_t      result
);

    dp_cmd_t cmd;

    spmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    spmq_dp #(
        .NUM_TASKS  (NUM_TASKS),
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .done    (done),
        .result  (result)
    );

    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.load, 3))
        else $error("result without a transaction three edges earlier");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter the access cycle");

    a_fail_no_message: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.message_out == 8'd0))
        else $error("failed transaction returned a message");

    a_empty_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> !result.pending)
        else $error("empty receive reported pending");

endmodule

`default_nettype wire
